// ===== rtl/core/assert_macros.svh =====
// assertion macros used by ray_box_slab_intersect_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rbsi_pkg.sv =====
// types and constants of the ray box slab intersection block
package rbsi_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_AXES   = 3;
  localparam int NUM_LANES  = 2 * NUM_AXES;
  localparam int REG_BITS   = 3;
  // magnitude of a corner minus origin difference
  localparam int NUM_BITS   = WORD_BITS + 1;
  // dividend after scaling by the fraction
  localparam int REM_BITS   = NUM_BITS + FRAC_BITS;
  // quotient magnitude bits below the sign
  localparam int QUO_BITS   = WORD_BITS - 1;
  localparam int CMP_BITS   = WORD_BITS + QUO_BITS;
  // input stage, saturation stage, one stage per quotient bit
  localparam int DIV_STAGES = QUO_BITS + 2;
  // slab value, ordering, reduction, final compare
  localparam int NUM_STAGES = DIV_STAGES + 4;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t DIR_RESET = word_t'(1) << FRAC_BITS;

  typedef enum logic [REG_BITS-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_T_MIN,
    REG_T_MAX
  } reg_idx_t;

  // payload of one divider stage: lanes 0..2 are min corners, 3..5 max corners
  typedef struct packed {
    logic [NUM_LANES-1:0][REM_BITS-1:0] rem;
    logic [NUM_LANES-1:0][QUO_BITS-1:0] quo;
    logic [NUM_LANES-1:0]               sat;
    logic [NUM_LANES-1:0]               neg;
    logic                               miss;
  } div_t;

endpackage

// ===== rtl/core/ray_box_slab_intersect_top.sv =====
// ray against axis-aligned box slab test, fully pipelined
// pipeline: 2 setup stages, one restoring divider stage per quotient bit for 31 bits,
//   then 4 stages of ordering and compare
// one box per cycle while the skid is empty, set by six parallel pipelined dividers
// a one-entry skid register at the output takes a result when the sink stalls
// reset (synchronous, active high) empties the pipeline and loads the ray defaults:
//   origin 0, direction (1.0, 0, 0), interval [0, largest value]
`include "assert_macros.svh"

module ray_box_slab_intersect_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [rbsi_pkg::REG_BITS-1:0]        cfg_index,
  input  logic [rbsi_pkg::WORD_BITS-1:0]       cfg_data,
  // box input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rbsi_pkg::WORD_BITS-1:0] box_min_x,
  input  logic signed [rbsi_pkg::WORD_BITS-1:0] box_min_y,
  input  logic signed [rbsi_pkg::WORD_BITS-1:0] box_min_z,
  input  logic signed [rbsi_pkg::WORD_BITS-1:0] box_max_x,
  input  logic signed [rbsi_pkg::WORD_BITS-1:0] box_max_y,
  input  logic signed [rbsi_pkg::WORD_BITS-1:0] box_max_z,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic signed [rbsi_pkg::WORD_BITS-1:0] entry_t
);

  localparam int W  = rbsi_pkg::WORD_BITS;
  localparam int NA = rbsi_pkg::NUM_AXES;
  localparam int NL = rbsi_pkg::NUM_LANES;
  localparam int DS = rbsi_pkg::DIV_STAGES;
  localparam int NS = rbsi_pkg::NUM_STAGES;

  // ray registers
  rbsi_pkg::word_t origin [NA];
  rbsi_pkg::word_t dir    [NA];
  rbsi_pkg::word_t t_min;
  rbsi_pkg::word_t t_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NA; a++) begin
        origin[a] <= '0;
        dir[a]    <= '0;
      end
      dir[0] <= rbsi_pkg::DIR_RESET;
      t_min  <= '0;
      t_max  <= rbsi_pkg::WORD_MAX;
    end else if (cfg_wr_en) begin
      case (rbsi_pkg::reg_idx_t'(cfg_index))
        rbsi_pkg::REG_ORIGIN_X: origin[0] <= cfg_data;
        rbsi_pkg::REG_ORIGIN_Y: origin[1] <= cfg_data;
        rbsi_pkg::REG_ORIGIN_Z: origin[2] <= cfg_data;
        rbsi_pkg::REG_DIR_X:    dir[0]    <= cfg_data;
        rbsi_pkg::REG_DIR_Y:    dir[1]    <= cfg_data;
        rbsi_pkg::REG_DIR_Z:    dir[2]    <= cfg_data;
        rbsi_pkg::REG_T_MIN:    t_min     <= cfg_data;
        rbsi_pkg::REG_T_MAX:    t_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // divisor magnitude, parallel flag per axis; user keeps dir static while boxes flow
  logic [W-1:0] ud   [NA];
  logic [NA-1:0] flat;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      ud[a]   = dir[a][W-1] ? (~dir[a] + W'(1)) : dir[a];
      flat[a] = (dir[a] == '0);
    end
  end

  // pipeline control: whole pipe moves unless the skid register is occupied
  logic          en;
  logic [NS-1:0] vld;
  logic          skid_full;
  logic          skid_hit;
  rbsi_pkg::word_t skid_entry;

  assign en       = !skid_full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // box corners per axis
  rbsi_pkg::word_t lo [NA];
  rbsi_pkg::word_t hi [NA];

  always_comb begin
    lo[0] = box_min_x;
    lo[1] = box_min_y;
    lo[2] = box_min_z;
    hi[0] = box_max_x;
    hi[1] = box_max_y;
    hi[2] = box_max_z;
  end

  // divider pipeline
  rbsi_pkg::div_t dstage [DS];
  rbsi_pkg::div_t dnext  [DS];

  // setup: corner minus origin, sign of the quotient, parallel axis check
  always_comb begin
    logic signed [rbsi_pkg::NUM_BITS-1:0] diff;
    logic [rbsi_pkg::NUM_BITS-1:0]        un;
    dnext[0] = '0;
    for (int a = 0; a < NA; a++) begin
      diff = {lo[a][W-1], lo[a]} - {origin[a][W-1], origin[a]};
      un   = diff[rbsi_pkg::NUM_BITS-1] ? rbsi_pkg::NUM_BITS'(-diff) : diff;
      dnext[0].rem[a] = {un, {rbsi_pkg::FRAC_BITS{1'b0}}};
      dnext[0].neg[a] = diff[rbsi_pkg::NUM_BITS-1] ^ dir[a][W-1];
      diff = {hi[a][W-1], hi[a]} - {origin[a][W-1], origin[a]};
      un   = diff[rbsi_pkg::NUM_BITS-1] ? rbsi_pkg::NUM_BITS'(-diff) : diff;
      dnext[0].rem[a+NA] = {un, {rbsi_pkg::FRAC_BITS{1'b0}}};
      dnext[0].neg[a+NA] = diff[rbsi_pkg::NUM_BITS-1] ^ dir[a][W-1];
      if (flat[a] && (origin[a] < lo[a] || origin[a] > hi[a])) begin
        dnext[0].miss = 1'b1;
      end
    end
  end

  // saturation: integer part of the quotient does not fit
  always_comb begin
    dnext[1] = dstage[0];
    for (int a = 0; a < NA; a++) begin
      dnext[1].sat[a] = rbsi_pkg::CMP_BITS'(dstage[0].rem[a]) >=
                        (rbsi_pkg::CMP_BITS'(ud[a]) << rbsi_pkg::QUO_BITS);
      dnext[1].sat[a+NA] = rbsi_pkg::CMP_BITS'(dstage[0].rem[a+NA]) >=
                           (rbsi_pkg::CMP_BITS'(ud[a]) << rbsi_pkg::QUO_BITS);
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 2; k < DS; k++) begin : g_div
    localparam int BIT = rbsi_pkg::QUO_BITS - 1 - (k - 2);
    always_comb begin
      logic [rbsi_pkg::CMP_BITS-1:0] trial;
      dnext[k] = dstage[k-1];
      for (int l = 0; l < NL; l++) begin
        trial = rbsi_pkg::CMP_BITS'(ud[(l < NA) ? l : l - NA]) << BIT;
        if (rbsi_pkg::CMP_BITS'(dstage[k-1].rem[l]) >= trial) begin
          dnext[k].rem[l]      = dstage[k-1].rem[l] - trial[rbsi_pkg::REM_BITS-1:0];
          dnext[k].quo[l][BIT] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DS; k++) begin
        dstage[k] <= dnext[k];
      end
    end
  end

  // slab values with sign and saturation applied
  rbsi_pkg::word_t p1_val [NL];
  logic            p1_miss;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        if (dstage[DS-1].sat[l]) begin
          p1_val[l] <= dstage[DS-1].neg[l] ? rbsi_pkg::WORD_MIN : rbsi_pkg::WORD_MAX;
        end else if (dstage[DS-1].neg[l]) begin
          p1_val[l] <= -{1'b0, dstage[DS-1].quo[l]};
        end else begin
          p1_val[l] <= {1'b0, dstage[DS-1].quo[l]};
        end
      end
      p1_miss <= dstage[DS-1].miss;
    end
  end

  // order near and far per axis, parallel axes take no part
  rbsi_pkg::word_t p2_tn [NA];
  rbsi_pkg::word_t p2_tf [NA];
  logic            p2_miss;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        if (flat[a]) begin
          p2_tn[a] <= rbsi_pkg::WORD_MIN;
          p2_tf[a] <= rbsi_pkg::WORD_MAX;
        end else if (p1_val[a] > p1_val[a+NA]) begin
          p2_tn[a] <= p1_val[a+NA];
          p2_tf[a] <= p1_val[a];
        end else begin
          p2_tn[a] <= p1_val[a];
          p2_tf[a] <= p1_val[a+NA];
        end
      end
      p2_miss <= p1_miss;
    end
  end

  // entry is the max of t_min and near values, exit the min of t_max and far values
  rbsi_pkg::word_t p3_t0;
  rbsi_pkg::word_t p3_t1;
  logic            p3_miss;
  rbsi_pkg::word_t p3_t0_next;
  rbsi_pkg::word_t p3_t1_next;

  always_comb begin : p3_reduce
    rbsi_pkg::word_t t0;
    rbsi_pkg::word_t t1;
    t0 = t_min;
    t1 = t_max;
    for (int a = 0; a < NA; a++) begin
      if (p2_tn[a] > t0) t0 = p2_tn[a];
      if (p2_tf[a] < t1) t1 = p2_tf[a];
    end
    p3_t0_next = t0;
    p3_t1_next = t1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_t0   <= p3_t0_next;
      p3_t1   <= p3_t1_next;
      p3_miss <= p2_miss;
    end
  end

  // final compare, entry forced to zero on a miss
  logic            p4_hit;
  rbsi_pkg::word_t p4_entry;
  logic            hit_next;

  assign hit_next = !p3_miss && (p3_t0 <= p3_t1);

  always_ff @(posedge clk) begin
    if (en) begin
      p4_hit   <= hit_next;
      p4_entry <= hit_next ? p3_t0 : '0;
    end
  end

  // skid register catches the last stage when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) skid_full <= 1'b0;
    end else if (vld[NS-1] && !out_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_hit   <= p4_hit;
      skid_entry <= p4_entry;
    end
  end

  assign out_valid = skid_full || vld[NS-1];
  assign hit       = skid_full ? skid_hit : p4_hit;
  assign entry_t   = skid_full ? skid_entry : p4_entry;

  // skid fills only from a stalled valid result
  `ASSERT_IMPLY(a_skid_fill, $rose(skid_full), $past(vld[NS-1] && !out_ready))
  // a miss always carries a zero entry
  `ASSERT_IMPLY(a_miss_entry, out_valid && !hit, entry_t == '0)
  // nothing leaves the block right after reset
  `ASSERT_ALWAYS(a_reset_empty, $past(rst) && !rst, !out_valid)

endmodule

// ===== test/tb_ray_box_slab_intersect_top.sv =====
// testbench of the ray against axis-aligned box slab intersection block
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect_top;

  localparam int LATENCY     = rbsi_pkg::NUM_STAGES + 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    rbsi_pkg::word_t lo [3];
    rbsi_pkg::word_t hi [3];
  } box_t;

  typedef struct {
    logic            hit;
    rbsi_pkg::word_t entry;
  } slab_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [rbsi_pkg::REG_BITS-1:0] cfg_index = '0;
  logic [rbsi_pkg::WORD_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  rbsi_pkg::word_t box_min_x = '0, box_min_y = '0, box_min_z = '0;
  rbsi_pkg::word_t box_max_x = '0, box_max_y = '0, box_max_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  rbsi_pkg::word_t entry_t;

  // testbench copy of the ray registers
  rbsi_pkg::word_t ray_reg [8];
  slab_result_t expected_results [$];
  int errors = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int boxes_sent = 0;
  int cycles = 0;

  ray_box_slab_intersect_top i_dut (.*);

  always #5 clk = ~clk;

  // cycle counter guards against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // random gap length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // slab distance (num << frac) / den, truncated toward zero and saturated
  function automatic rbsi_pkg::word_t slab_quotient(longint num, longint den);
    bit neg;
    longint unsigned un, ud, q;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if (un / ud >= (64'd1 << (rbsi_pkg::WORD_BITS - 1 - rbsi_pkg::FRAC_BITS)))
      return neg ? rbsi_pkg::WORD_MIN : rbsi_pkg::WORD_MAX;
    q = (un << rbsi_pkg::FRAC_BITS) / ud;
    return neg ? rbsi_pkg::word_t'(-longint'(q)) : rbsi_pkg::word_t'(q);
  endfunction

  function automatic slab_result_t box_intersection(box_t b);
    slab_result_t res;
    longint t_enter, t_exit, org, dir, lo, hi, tn, tf, tmp;
    bit miss;
    t_enter = ray_reg[rbsi_pkg::REG_T_MIN];
    t_exit  = ray_reg[rbsi_pkg::REG_T_MAX];
    miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      org = ray_reg[rbsi_pkg::REG_ORIGIN_X + a];
      dir = ray_reg[rbsi_pkg::REG_DIR_X + a];
      lo = b.lo[a];
      hi = b.hi[a];
      if (dir == 0) begin
        // parallel axis: origin must sit inside the slab
        if (org < lo || org > hi) miss = 1'b1;
      end else begin
        tn = slab_quotient(lo - org, dir);
        tf = slab_quotient(hi - org, dir);
        if (tn > tf) begin
          tmp = tn; tn = tf; tf = tmp;
        end
        if (tn > t_enter) t_enter = tn;
        if (tf < t_exit) t_exit = tf;
      end
    end
    if (t_enter > t_exit) miss = 1'b1;
    res.hit = !miss;
    res.entry = miss ? '0 : rbsi_pkg::word_t'(t_enter);
    return res;
  endfunction

  task automatic write_reg(rbsi_pkg::reg_idx_t idx, rbsi_pkg::word_t value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    ray_reg[idx] = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_ray(rbsi_pkg::word_t ox, rbsi_pkg::word_t oy, rbsi_pkg::word_t oz,
                         rbsi_pkg::word_t dx, rbsi_pkg::word_t dy, rbsi_pkg::word_t dz,
                         rbsi_pkg::word_t t0, rbsi_pkg::word_t t1);
    write_reg(rbsi_pkg::REG_ORIGIN_X, ox);
    write_reg(rbsi_pkg::REG_ORIGIN_Y, oy);
    write_reg(rbsi_pkg::REG_ORIGIN_Z, oz);
    write_reg(rbsi_pkg::REG_DIR_X, dx);
    write_reg(rbsi_pkg::REG_DIR_Y, dy);
    write_reg(rbsi_pkg::REG_DIR_Z, dz);
    write_reg(rbsi_pkg::REG_T_MIN, t0);
    write_reg(rbsi_pkg::REG_T_MAX, t1);
  endtask

  // one box transfer; valid drops only for a gap, prediction is queued at acceptance
  task automatic send_box(box_t b, bit no_gap = 1'b0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid  <= 1'b1;
    box_min_x <= b.lo[0]; box_min_y <= b.lo[1]; box_min_z <= b.lo[2];
    box_max_x <= b.hi[0]; box_max_y <= b.hi[1]; box_max_z <= b.hi[2];
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(box_intersection(b));
    boxes_sent++;
    @(negedge clk);
  endtask

  // wait until the pipeline is drained before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // sink side stalls at random
  initial begin
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(8, 30)) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) < 10) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // compare every result transfer against the oldest prediction
  always @(posedge clk) begin
    slab_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (hit) hits_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0b entry=%0d", hit, entry_t);
      end else begin
        exp_r = expected_results.pop_front();
        if (hit !== exp_r.hit || entry_t !== exp_r.entry) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected hit=%0b entry=%0d, got hit=%0b entry=%0d",
                     exp_r.hit, exp_r.entry, hit, entry_t);
        end
      end
    end
  end

  function automatic rbsi_pkg::word_t rand_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return rbsi_pkg::WORD_MAX;
      1: return rbsi_pkg::WORD_MIN;
      2: return '0;
      3: return $urandom;
      default: return rbsi_pkg::word_t'(
                 $signed($urandom_range(0, 40 << rbsi_pkg::FRAC_BITS)) -
                 (20 << rbsi_pkg::FRAC_BITS));
    endcase
  endfunction

  function automatic box_t rand_box(bit ordered);
    box_t b;
    rbsi_pkg::word_t t;
    for (int a = 0; a < 3; a++) begin
      b.lo[a] = rand_word();
      b.hi[a] = rand_word();
      if (ordered && b.lo[a] > b.hi[a]) begin
        t = b.lo[a]; b.lo[a] = b.hi[a]; b.hi[a] = t;
      end
    end
    return b;
  endfunction

  function automatic box_t make_box(rbsi_pkg::word_t l0, rbsi_pkg::word_t l1,
                                    rbsi_pkg::word_t l2, rbsi_pkg::word_t h0,
                                    rbsi_pkg::word_t h1, rbsi_pkg::word_t h2);
    box_t b;
    b.lo = '{l0, l1, l2};
    b.hi = '{h0, h1, h2};
    return b;
  endfunction

  // reset ray: unit x direction, y and z parallel at origin
  task automatic test_reset_ray();
    localparam rbsi_pkg::word_t ONE = rbsi_pkg::word_t'(1) << rbsi_pkg::FRAC_BITS;
    send_box(make_box(ONE, -ONE, -ONE, 3 * ONE, ONE, ONE));
    send_box(make_box(ONE, 0, 0, 3 * ONE, 0, 0));          // origin on faces
    send_box(make_box(ONE, ONE, -ONE, 3 * ONE, 2 * ONE, ONE)); // parallel miss
    send_box(make_box(-3 * ONE, -ONE, -ONE, -ONE, ONE, ONE)); // behind
    send_box(make_box(ONE, ONE, -ONE, 3 * ONE, -ONE, ONE));   // inverted parallel
    send_box(make_box(rbsi_pkg::WORD_MIN, rbsi_pkg::WORD_MIN, rbsi_pkg::WORD_MIN,
                      rbsi_pkg::WORD_MAX, rbsi_pkg::WORD_MAX, rbsi_pkg::WORD_MAX));
    send_box(make_box(rbsi_pkg::WORD_MAX, 0, 0, rbsi_pkg::WORD_MAX, 0, 0));
    send_box(make_box(3 * ONE, -ONE, -ONE, ONE, ONE, ONE));   // inverted slab
    drain();
  endtask

  // extreme ray settings: tiny directions saturate, extreme origins and intervals
  task automatic test_extremes();
    set_ray(rbsi_pkg::WORD_MIN, rbsi_pkg::WORD_MAX, 0, 1, -1, rbsi_pkg::WORD_MIN,
            rbsi_pkg::WORD_MIN, rbsi_pkg::WORD_MAX);
    for (int i = 0; i < 6; i++) send_box(rand_box(1'b1));
    send_box(make_box(rbsi_pkg::WORD_MIN, rbsi_pkg::WORD_MIN, rbsi_pkg::WORD_MIN,
                      rbsi_pkg::WORD_MAX, rbsi_pkg::WORD_MAX, rbsi_pkg::WORD_MAX));
    drain();
    set_ray(rbsi_pkg::WORD_MAX, rbsi_pkg::WORD_MIN, rbsi_pkg::WORD_MAX,
            rbsi_pkg::WORD_MAX, rbsi_pkg::WORD_MIN, -1,
            rbsi_pkg::WORD_MAX, rbsi_pkg::WORD_MIN);
    for (int i = 0; i < 5; i++) send_box(rand_box(1'b0));
    drain();
  endtask

  // random rays, each with a burst of boxes, mostly well ordered
  task automatic test_random_rays(int n_boxes);
    rbsi_pkg::word_t d [3];
    int sent;
    sent = 0;
    while (sent < n_boxes) begin
      for (int a = 0; a < 3; a++)
        d[a] = ($urandom_range(0, 5) == 0) ? '0 : rand_word();
      set_ray(rand_word(), rand_word(), rand_word(), d[0], d[1], d[2],
              ($urandom_range(0, 2) == 0) ? rand_word() : rbsi_pkg::word_t'(0),
              ($urandom_range(0, 2) == 0) ? rand_word() : rbsi_pkg::WORD_MAX);
      for (int i = 0; i < 60 && sent < n_boxes; i++, sent++)
        send_box(rand_box($urandom_range(0, 9) != 0), $urandom_range(0, 4) == 0);
      drain();
    end
  endtask

  initial begin
    ray_reg[rbsi_pkg::REG_ORIGIN_X] = '0;
    ray_reg[rbsi_pkg::REG_ORIGIN_Y] = '0;
    ray_reg[rbsi_pkg::REG_ORIGIN_Z] = '0;
    ray_reg[rbsi_pkg::REG_DIR_X] = rbsi_pkg::DIR_RESET;
    ray_reg[rbsi_pkg::REG_DIR_Y] = '0;
    ray_reg[rbsi_pkg::REG_DIR_Z] = '0;
    ray_reg[rbsi_pkg::REG_T_MIN] = '0;
    ray_reg[rbsi_pkg::REG_T_MAX] = rbsi_pkg::WORD_MAX;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_reset_ray();
    test_extremes();
    test_random_rays(1430);
    repeat (LATENCY) @(negedge clk);
    $display("sent %0d boxes, checked %0d results, %0d hits", boxes_sent, results_seen,
             hits_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rbsi_pkg.sv
rtl/core/ray_box_slab_intersect_top.sv
test/tb_ray_box_slab_intersect_top.sv
